FILE: hdl/cubemap_face_source_address_unit_macros.svh
// ----------------------------------------------------------------------------
// cubemap face source address unit assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_FACE_SOURCE_ADDRESS_UNIT_MACROS_SVH
`define CUBEMAP_FACE_SOURCE_ADDRESS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFSAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CFSAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define CFSAU_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cfsau_pkg.sv
// ----------------------------------------------------------------------------
// cfsau_pkg
// types, codes and tables of the cube face source address unit
// ----------------------------------------------------------------------------
`default_nettype none
package cfsau_pkg;

    localparam int DIV_BITS = 28;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [2:0] CFG_FACE_COLS = 3'd0;
    localparam logic [2:0] CFG_FACE_ROWS = 3'd1;
    localparam logic [2:0] CFG_HALF_FOV_TAN = 3'd2;
    localparam logic [2:0] CFG_SRC_COLS = 3'd3;
    localparam logic [2:0] CFG_SRC_ROWS = 3'd4;

    localparam logic [2:0] FACE_FRONT = 3'd0;
    localparam logic [2:0] FACE_RIGHT = 3'd1;
    localparam logic [2:0] FACE_BACK = 3'd2;
    localparam logic [2:0] FACE_LEFT = 3'd3;
    localparam logic [2:0] FACE_TOP = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic                neg;
        logic [11:0]         rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic                  valid;
        logic [2:0]            face;
        t_div_lane [1:0]       lane;
    } t_div_pipe;

    typedef struct packed {
        logic               valid;
        logic               zflag;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        z;
        logic [31:0]        aux;
    } t_cordic_pipe;

endpackage
`default_nettype wire

FILE: hdl/cfsau_div_cell.sv
// ----------------------------------------------------------------------------
// cfsau_div_cell
// one restoring division step for the column and row lanes
// ----------------------------------------------------------------------------
`default_nettype none
module cfsau_div_cell
    import cfsau_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [1:0][11:0] i_div,
    input  wire t_div_pipe        i_pipe,
    output t_div_pipe             o_pipe
);

    t_div_pipe n_pipe;
    t_div_pipe r_pipe;

    always_comb begin
        logic [12:0] t;
        n_pipe = i_pipe;
        for (int l = 0; l < 2; l++) begin
            t = {i_pipe.lane[l].rem, i_pipe.lane[l].num[DIV_BITS-1]};
            n_pipe.lane[l].num = {i_pipe.lane[l].num[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, i_div[l]}) begin
                n_pipe.lane[l].rem = 12'(t - {1'b0, i_div[l]});
                n_pipe.lane[l].quo = {i_pipe.lane[l].quo[DIV_BITS-2:0], 1'b1};
            end else begin
                n_pipe.lane[l].rem = t[11:0];
                n_pipe.lane[l].quo = {i_pipe.lane[l].quo[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule
`default_nettype wire

FILE: hdl/cfsau_cordic_cell.sv
// ----------------------------------------------------------------------------
// cfsau_cordic_cell
// one vectoring micro-rotation toward the positive x axis
// ----------------------------------------------------------------------------
`default_nettype none
module cfsau_cordic_cell
    import cfsau_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_cordic_pipe i_pipe,
    output t_cordic_pipe      o_pipe
);

    t_cordic_pipe n_pipe;
    t_cordic_pipe r_pipe;

    always_comb begin
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = i_pipe.y >>> IDX;
        dy = i_pipe.x >>> IDX;
        n_pipe = i_pipe;
        if (i_pipe.y > 0) begin
            n_pipe.x = i_pipe.x + dx;
            n_pipe.y = i_pipe.y - dy;
            n_pipe.z = i_pipe.z + ATAN_TURNS[IDX];
        end else begin
            n_pipe.x = i_pipe.x - dx;
            n_pipe.y = i_pipe.y + dy;
            n_pipe.z = i_pipe.z - ATAN_TURNS[IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule
`default_nettype wire

FILE: hdl/cfsau_cordic.sv
// ----------------------------------------------------------------------------
// cfsau_cordic
// half-plane fold followed by a chain of vectoring cells
// ----------------------------------------------------------------------------
`default_nettype none
module cfsau_cordic
    import cfsau_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire t_cordic_pipe i_pipe,
    output t_cordic_pipe      o_pipe
);

    t_cordic_pipe n_fold;
    t_cordic_pipe r_fold;
    t_cordic_pipe w_chain [STAGES+1];

    // left half plane: rotate by half a turn first
    always_comb begin
        n_fold = i_pipe;
        n_fold.z = '0;
        if (i_pipe.x < 0) begin
            n_fold.x = -i_pipe.x;
            n_fold.y = -i_pipe.y;
            n_fold.z = 32'h8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= '0;
        end else if (i_en) begin
            r_fold <= n_fold;
        end
    end

    assign w_chain[0] = r_fold;

    for (genvar k = 0; k < STAGES; k++) begin : g_cell
        cfsau_cordic_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_pipe  (w_chain[k]),
            .o_pipe  (w_chain[k+1])
        );
    end

    assign o_pipe = w_chain[STAGES];

endmodule
`default_nettype wire

FILE: hdl/cubemap_face_source_address_unit.sv
// ----------------------------------------------------------------------------
// cubemap_face_source_address_unit
// maps a cube face pixel to its equirectangular source pixel
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  face_sel, pix_col, pix_row
//  m_axis    out  m_axis_tvalid / m_axis_tready  src_x, src_y
//  cfg       in   i_cfg_valid / o_cfg_ready      register index, data
//
//  one request per cycle while the output buffer has room
//  the divider cells, the two cordic cell chains and the stage registers around them set the depth
//  a two-entry output buffer holds results; the pipe freezes only when it is full
//  reset is synchronous and active low; configuration registers return to their defaults
//  requests with a face code above five are dropped without a result
// ----------------------------------------------------------------------------
`default_nettype none
module cubemap_face_source_address_unit
    import cfsau_pkg::*;
#(
    parameter int MAX_FACE_SIZE = 2048,
    parameter int MAX_SRC_SIZE  = 8192,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // face_sel[2:0], pix_col[13:3], pix_row[24:14]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // src_x[12:0], src_y[25:13]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    logic [11:0] r_face_cols;
    logic [11:0] r_face_rows;
    logic [19:0] r_half_fov_tan;
    logic [13:0] r_src_cols;
    logic [13:0] r_src_rows;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_cols    <= 12'd512;
            r_face_rows    <= 12'd512;
            r_half_fov_tan <= 20'd65536;
            r_src_cols     <= 14'd4096;
            r_src_rows     <= 14'd2048;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FACE_COLS:    r_face_cols    <= i_cfg_data[11:0];
                CFG_FACE_ROWS:    r_face_rows    <= i_cfg_data[11:0];
                CFG_HALF_FOV_TAN: r_half_fov_tan <= i_cfg_data;
                CFG_SRC_COLS:     r_src_cols     <= i_cfg_data[13:0];
                CFG_SRC_ROWS:     r_src_rows     <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [11:0] w_fw, w_fh;
    logic [13:0] w_sw, w_sh;

    always_comb begin
        w_fw = (r_face_cols == '0) ? 12'd1 :
               (r_face_cols > MAX_FACE_SIZE) ? 12'(MAX_FACE_SIZE) : r_face_cols;
        w_fh = (r_face_rows == '0) ? 12'd1 :
               (r_face_rows > MAX_FACE_SIZE) ? 12'(MAX_FACE_SIZE) : r_face_rows;
        w_sw = (r_src_cols == '0) ? 14'd1 :
               (r_src_cols > MAX_SRC_SIZE) ? 14'(MAX_SRC_SIZE) : r_src_cols;
        w_sh = (r_src_rows == '0) ? 14'd1 :
               (r_src_rows > MAX_SRC_SIZE) ? 14'(MAX_SRC_SIZE) : r_src_rows;
    end

    // output buffer and pipe enable
    logic [1:0]  r_cnt;
    logic [25:0] r_q0, r_q1;
    logic        w_en;
    logic        w_push, w_pop;
    logic [25:0] w_res;

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    // request decode into the first divider cell
    logic [2:0]  w_face;
    logic [10:0] w_col, w_row;
    t_div_pipe   w_div [DIV_BITS+1];
    logic [1:0][11:0] w_divisor;

    assign w_face = s_axis_tdata[2:0];
    assign w_col  = s_axis_tdata[13:3];
    assign w_row  = s_axis_tdata[24:14];
    assign w_divisor[0] = w_fw;
    assign w_divisor[1] = w_fh;

    always_comb begin
        logic signed [12:0] d [2];
        d[0] = $signed({1'b0, w_col, 1'b0}) - $signed({1'b0, w_fw});
        d[1] = $signed({1'b0, w_row, 1'b0}) - $signed({1'b0, w_fh});
        w_div[0].valid = s_axis_tvalid && w_en && (w_face <= FACE_BOTTOM);
        w_div[0].face  = w_face;
        for (int l = 0; l < 2; l++) begin
            w_div[0].lane[l].neg = d[l][12];
            w_div[0].lane[l].rem = '0;
            w_div[0].lane[l].num = d[l][12] ? {12'(-d[l]), 16'd0} : {d[l][11:0], 16'd0};
            w_div[0].lane[l].quo = '0;
        end
    end

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
        cfsau_div_cell u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_divisor),
            .i_pipe  (w_div[i]),
            .o_pipe  (w_div[i+1])
        );
    end

    // floor the quotient and saturate to q4.16
    logic                r_s1_valid;
    logic [2:0]          r_s1_face;
    logic signed [20:0]  r_s1_a [2];
    logic signed [20:0]  n_s1_a [2];

    always_comb begin
        logic [DIV_BITS:0] qq;
        qq = '0;
        for (int l = 0; l < 2; l++) begin
            if (w_div[DIV_BITS].lane[l].neg) begin
                qq = {1'b0, w_div[DIV_BITS].lane[l].quo}
                     + (DIV_BITS+1)'(w_div[DIV_BITS].lane[l].rem != '0);
                n_s1_a[l] = (qq > (DIV_BITS+1)'(1 << 20)) ? -21'sd1048576 : -$signed(qq[20:0]);
            end else begin
                n_s1_a[l] = (w_div[DIV_BITS].lane[l].quo > DIV_BITS'(1048575)) ?
                            21'sd1048575 : $signed(w_div[DIV_BITS].lane[l].quo[20:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_div[DIV_BITS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_face <= w_div[DIV_BITS].face;
            r_s1_a    <= n_s1_a;
        end
    end

    // scale by the half fov tangent
    logic                r_s2_valid;
    logic [2:0]          r_s2_face;
    logic signed [20:0]  r_s2_c [2];
    logic signed [20:0]  n_s2_c [2];

    always_comb begin
        logic signed [41:0] p;
        logic signed [25:0] s;
        for (int l = 0; l < 2; l++) begin
            p = r_s1_a[l] * $signed({1'b0, r_half_fov_tan});
            s = p[41:16];
            n_s2_c[l] = (s > 26'sd1048575) ? 21'sd1048575 :
                        (s < -26'sd1048576) ? -21'sd1048576 : s[20:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_face <= r_s1_face;
            r_s2_c    <= n_s2_c;
        end
    end

    // face direction, scaled up by 256
    t_cordic_pipe w_c1_in, w_c1_out;

    always_comb begin
        logic signed [31:0] x, y, one;
        logic signed [31:0] nx, ny, nz;
        x   = 32'(r_s2_c[0]) <<< 8;
        y   = 32'(r_s2_c[1]) <<< 8;
        one = 32'sd16777216;
        case (r_s2_face)
            FACE_FRONT:  begin nx = x;    ny = y;    nz = one;  end
            FACE_RIGHT:  begin nx = one;  ny = y;    nz = -x;   end
            FACE_BACK:   begin nx = -x;   ny = y;    nz = -one; end
            FACE_LEFT:   begin nx = -one; ny = y;    nz = x;    end
            FACE_TOP:    begin nx = x;    ny = one;  nz = -y;   end
            default:     begin nx = x;    ny = -one; nz = y;    end
        endcase
        w_c1_in.valid = r_s2_valid;
        w_c1_in.zflag = (nx == 0) && (nz == 0);
        w_c1_in.x     = nz;
        w_c1_in.y     = nx;
        w_c1_in.z     = '0;
        w_c1_in.aux   = ny;
    end

    cfsau_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_pipe  (w_c1_in),
        .o_pipe  (w_c1_out)
    );

    // longitude and gain-corrected horizontal length
    logic               r_s3_valid;
    logic [31:0]        r_s3_theta;
    logic signed [31:0] r_s3_r;
    logic signed [31:0] r_s3_ny;
    logic signed [48:0] w_mag_p;

    assign w_mag_p = w_c1_out.x * 17'sd39797;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= w_c1_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_theta <= w_c1_out.zflag ? 32'd0 : w_c1_out.z;
            r_s3_r     <= w_c1_out.zflag ? 32'sd0 : w_mag_p[47:16];
            r_s3_ny    <= w_c1_out.aux;
        end
    end

    t_cordic_pipe w_c2_in, w_c2_out;

    always_comb begin
        w_c2_in.valid = r_s3_valid;
        w_c2_in.zflag = 1'b0;
        w_c2_in.x     = r_s3_r;
        w_c2_in.y     = r_s3_ny;
        w_c2_in.z     = '0;
        w_c2_in.aux   = r_s3_theta;
    end

    cfsau_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_pipe  (w_c2_in),
        .o_pipe  (w_c2_out)
    );

    // scale angles to source pixels
    logic               r_o1_valid;
    logic [13:0]        r_o1_px;
    logic signed [16:0] r_o1_py;
    logic [31:0]        w_uu;
    logic [45:0]        w_px_p;
    logic signed [33:0] w_vv;
    logic signed [48:0] w_py_p;

    // longitude offset by half a turn wraps at 32 bits
    assign w_uu   = w_c2_out.aux + 32'h8000_0000;
    assign w_px_p = w_uu * w_sw;
    assign w_vv   = $signed({w_c2_out.z[31], w_c2_out.z, 1'b0}) + 34'sh0_8000_0000;
    assign w_py_p = w_vv * $signed({1'b0, w_sh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_valid <= 1'b0;
        end else if (w_en) begin
            r_o1_valid <= w_c2_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o1_px <= w_px_p[45:32];
            r_o1_py <= w_py_p[48:32];
        end
    end

    always_comb begin
        logic [12:0] sx, sy;
        sx = (r_o1_px >= w_sw) ? 13'd0 : r_o1_px[12:0];
        if (r_o1_py < 0) begin
            sy = '0;
        end else if (r_o1_py > $signed({3'b0, w_sh} - 17'd1)) begin
            sy = 13'(w_sh - 14'd1);
        end else begin
            sy = r_o1_py[12:0];
        end
        w_res = {sy, sx};
    end

    assign w_push = r_o1_valid && w_en;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= 2'(r_cnt + 2'(w_push) - 2'(w_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q0 <= (w_push && r_cnt == 2'd1) ? w_res : r_q1;
            if (w_push && r_cnt == 2'd2) begin
                r_q1 <= w_res;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_res;
            end else begin
                r_q1 <= w_res;
            end
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {6'd0, r_q0};

endmodule
`default_nettype wire

FILE: hdl/cfsau_checker.sv
// ----------------------------------------------------------------------------
// cfsau_checker
// port-level checks of the cube face source address unit
// ----------------------------------------------------------------------------
`default_nettype none
module cfsau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

`include "cubemap_face_source_address_unit_macros.svh"

    // a result waiting for the sink keeps its place
    `CFSAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    // the request side only stalls behind a pending result
    `CFSAU_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "request side stalled with no pending result")

    // no result survives reset
    `CFSAU_ASSERT_RST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result pending after reset")

    // padding above the source row stays clear
    `CFSAU_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:26] == 6'd0, "nonzero padding in result")

endmodule

bind cubemap_face_source_address_unit cfsau_checker u_cfsau_checker (.*);
`default_nettype wire
